// ----- rtl/core/sbct_pkg.sv -----
`default_nettype none

package sbct_pkg;

    localparam int CNT_W = 48;
    localparam int ADDR_W = 32;
    localparam int PROTO_W = 8;
    localparam int LEN_W = 16;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] OUTCOME_MATCH = 2'd0;
    localparam logic [1:0] OUTCOME_INSERT = 2'd1;
    localparam logic [1:0] OUTCOME_FULL = 2'd2;

    localparam logic [1:0] CLASS_TCP = 2'd0;
    localparam logic [1:0] CLASS_UDP = 2'd1;
    localparam logic [1:0] CLASS_ICMP = 2'd2;
    localparam logic [1:0] CLASS_OTHER = 2'd3;

    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;
    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;

    typedef struct packed {
        logic [ADDR_W-1:0]  source_address;
        logic [PROTO_W-1:0] protocol_number;
        logic [LEN_W-1:0]   packet_length;
    } header_t;

    typedef struct packed {
        logic [1:0]       outcome;
        logic [5:0]       slot;
        logic [CNT_W-1:0] source_byte_count;
        logic [1:0]       protocol_class;
        logic [CNT_W-1:0] class_packet_count;
        logic [CNT_W-1:0] packet_total;
        logic [CNT_W-1:0] byte_total;
        logic [6:0]       sources_tracked;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [CNT_W-1:0]  byte_count;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic hit_done;
        logic advance;
        logic insert;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic occ_zero;
        logic match;
        logic last;
    } status_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

    function automatic logic [1:0] class_of(input logic [PROTO_W-1:0] proto);
        logic [1:0] cls;
        case (proto)
            PROTO_TCP:  cls = CLASS_TCP;
            PROTO_UDP:  cls = CLASS_UDP;
            PROTO_ICMP: cls = CLASS_ICMP;
            default:    cls = CLASS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sbct_ram.sv -----
`default_nettype none

module sbct_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sbct_ctrl.sv -----
`default_nettype none

module sbct_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire sbct_pkg::status_t status,
    output logic                  busy,
    output sbct_pkg::cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_CMP    = 4'b0100,
        ST_INSERT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = status.occ_zero ? ST_INSERT : ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.match)
                begin
                    cmd.hit_done = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.last)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/sbct_datapath.sv -----
`default_nettype none

module sbct_datapath #(
    parameter int TABLE_ENTRIES = sbct_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sbct_pkg::header_t header,
    input  wire sbct_pkg::cmd_t    cmd,
    output sbct_pkg::status_t      status,
    output sbct_pkg::result_t      result,
    output logic                   done
);

    localparam int IW = $clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int WW = CW + 7;
    localparam int EW = $bits(sbct_pkg::entry_t);
    localparam logic [CW-1:0] OCC_MAX = CW'(TABLE_ENTRIES);

    logic [sbct_pkg::ADDR_W-1:0] addr_reg;
    logic [sbct_pkg::LEN_W-1:0]  len_reg;
    logic [1:0]                  cls_reg;
    logic [IW-1:0]               idx_reg;
    logic [IW-1:0]               idx_next;
    logic [CW-1:0]               occ_reg;
    logic [CW-1:0]               occ_next;
    logic [sbct_pkg::CNT_W-1:0]  pkt_cnt_reg;
    logic [sbct_pkg::CNT_W-1:0]  byte_cnt_reg;
    logic [sbct_pkg::CNT_W-1:0]  class_cnt_reg [4];
    sbct_pkg::result_t           result_reg;
    sbct_pkg::result_t           result_next;
    logic                        done_reg;

    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    sbct_pkg::entry_t            ram_wdata;
    sbct_pkg::entry_t            ram_rdata;
    logic [EW-1:0]               ram_rdata_raw;

    logic [1:0]                  in_cls;
    logic                        full;
    logic [sbct_pkg::CNT_W-1:0]  hit_count;
    logic [sbct_pkg::CNT_W-1:0]  len_ext;
    logic [CW-1:0]               idx_ext;
    logic [WW-1:0]               idx_wide;
    logic [WW-1:0]               occ_wide;
    logic [WW-1:0]               occ_next_wide;

    sbct_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.read),
        .raddr(idx_reg),
        .rdata(ram_rdata_raw)
    );

    assign ram_rdata = sbct_pkg::entry_t'(ram_rdata_raw);

    assign in_cls = sbct_pkg::class_of(header.protocol_number);
    assign full = (occ_reg == OCC_MAX);
    assign len_ext = sbct_pkg::CNT_W'(len_reg);
    assign hit_count = sbct_pkg::sat_add(ram_rdata.byte_count, len_ext);
    assign idx_ext = CW'(idx_reg);

    assign status.occ_zero = (occ_reg == '0);
    assign status.match = (ram_rdata.address == addr_reg);
    assign status.last = ((idx_ext + CW'(1)) == occ_reg);

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata.address = addr_reg;
        ram_wdata.byte_count = hit_count;
        if (cmd.hit_done)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.insert && !full)
        begin
            ram_we = 1'b1;
            ram_waddr = occ_reg[IW-1:0];
            ram_wdata.byte_count = len_ext;
        end
    end

    assign idx_wide = WW'(idx_reg);
    assign occ_wide = WW'(occ_reg);
    assign occ_next_wide = WW'(occ_next);

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.insert && !full)
        begin
            occ_next = occ_reg + CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.advance)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    always_comb
    begin
        result_next = result_reg;
        result_next.protocol_class = cls_reg;
        result_next.class_packet_count = class_cnt_reg[cls_reg];
        result_next.packet_total = pkt_cnt_reg;
        result_next.byte_total = byte_cnt_reg;
        result_next.sources_tracked = occ_next_wide[6:0];
        if (cmd.hit_done)
        begin
            result_next.outcome = sbct_pkg::OUTCOME_MATCH;
            result_next.slot = idx_wide[5:0];
            result_next.source_byte_count = hit_count;
        end
        else if (!full)
        begin
            result_next.outcome = sbct_pkg::OUTCOME_INSERT;
            result_next.slot = occ_wide[5:0];
            result_next.source_byte_count = len_ext;
        end
        else
        begin
            result_next.outcome = sbct_pkg::OUTCOME_FULL;
            result_next.slot = '0;
            result_next.source_byte_count = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            occ_reg <= '0;
            pkt_cnt_reg <= '0;
            byte_cnt_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                class_cnt_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            occ_reg <= occ_next;
            done_reg <= cmd.hit_done | cmd.insert;
            // totals advance at the transfer, whatever the table does
            if (cmd.load)
            begin
                pkt_cnt_reg <= sbct_pkg::sat_add(pkt_cnt_reg, sbct_pkg::CNT_W'(1));
                byte_cnt_reg <= sbct_pkg::sat_add(byte_cnt_reg,
                                                  sbct_pkg::CNT_W'(header.packet_length));
                for (int i = 0; i < 4; i++)
                begin
                    if (in_cls == 2'(i))
                    begin
                        class_cnt_reg[i] <= sbct_pkg::sat_add(class_cnt_reg[i],
                                                              sbct_pkg::CNT_W'(1));
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= header.source_address;
            len_reg <= header.packet_length;
            cls_reg <= in_cls;
        end
        if (cmd.hit_done || cmd.insert)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/core/source_byte_counter_table.sv -----
`default_nettype none

// channel   signals                 transfer
// header    start, busy, header     start high while busy low
// result    done, result            done high, one cycle, cannot be stalled
//
// the source table is scanned one entry at a time through the registered ram read port;
// each entry is read in ST_READ and compared in ST_CMP, a hit writes the new count back,
// a miss past the last tracked source or an empty table goes to ST_INSERT; done is registered
// busy drops in the cycle done is high, so a new header may follow at once
// reset clears the totals and the occupancy; table entries at or above the
// occupancy are never read, so the ram needs no clearing pass

module source_byte_counter_table #(
    parameter int TABLE_ENTRIES = sbct_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sbct_pkg::header_t header,
    output logic                   done,
    output sbct_pkg::result_t      result
);

    sbct_pkg::cmd_t    cmd;
    sbct_pkg::status_t status;

    sbct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .busy  (busy),
        .cmd   (cmd)
    );

    sbct_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .header(header),
        .cmd   (cmd),
        .status(status),
        .result(result),
        .done  (done)
    );

`ifndef SYNTHESIS
    a_done_follows_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.hit_done || cmd.insert))
        else $error("done without a finishing step");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after header transfer");

    a_idle_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("still busy while result is shown");

    a_full_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.outcome == sbct_pkg::OUTCOME_FULL)
            |-> (result.slot == '0 && result.source_byte_count == '0))
        else $error("untracked result carries a slot or count");
`endif

endmodule

`default_nettype wire

// ----- tb/source_byte_counter_table_checker.sv -----
`default_nettype none

module source_byte_counter_table_checker #(
    parameter int TABLE_ENTRIES = sbct_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire sbct_pkg::header_t header,
    input  wire logic              done,
    input  wire sbct_pkg::result_t result,
    output int                     outstanding,
    output int                     mismatches,
    output int                     matched,
    output int                     inserted,
    output int                     untracked
);

    import sbct_pkg::*;

    // shadow of the flow table and the counters
    logic [ADDR_W-1:0] flow_addr [TABLE_ENTRIES];
    logic [CNT_W-1:0]  flow_bytes [TABLE_ENTRIES];
    int                flow_count;
    logic [CNT_W-1:0]  class_pkts [4];
    logic [CNT_W-1:0]  pkt_total;
    logic [CNT_W-1:0]  byte_total;

    result_t expected_reports[$];
    int      errs;
    int      n_match;
    int      n_insert;
    int      n_full;

    function automatic logic [CNT_W-1:0] add_sat48(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        return (s > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    task automatic account_packet(input header_t h, output result_t r);
        logic [1:0]       cls;
        logic [CNT_W-1:0] len;
        int               hit_idx;
        case (h.protocol_number)
            PROTO_TCP:  cls = CLASS_TCP;
            PROTO_UDP:  cls = CLASS_UDP;
            PROTO_ICMP: cls = CLASS_ICMP;
            default:    cls = CLASS_OTHER;
        endcase
        len = CNT_W'(h.packet_length);
        pkt_total = add_sat48(pkt_total, CNT_W'(1));
        byte_total = add_sat48(byte_total, len);
        class_pkts[cls] = add_sat48(class_pkts[cls], CNT_W'(1));

        r = '0;
        r.outcome = OUTCOME_FULL;
        r.protocol_class = cls;
        hit_idx = -1;
        for (int i = 0; i < flow_count; i++)
        begin
            if (hit_idx < 0 && flow_addr[i] == h.source_address)
                hit_idx = i;
        end
        if (hit_idx >= 0)
        begin
            flow_bytes[hit_idx] = add_sat48(flow_bytes[hit_idx], len);
            r.outcome = OUTCOME_MATCH;
            r.slot = 6'(hit_idx);
            r.source_byte_count = flow_bytes[hit_idx];
        end
        else if (flow_count < TABLE_ENTRIES)
        begin
            flow_addr[flow_count] = h.source_address;
            flow_bytes[flow_count] = len;
            r.outcome = OUTCOME_INSERT;
            r.slot = 6'(flow_count);
            r.source_byte_count = len;
            flow_count++;
        end
        r.class_packet_count = class_pkts[cls];
        r.packet_total = pkt_total;
        r.byte_total = byte_total;
        r.sources_tracked = 7'(flow_count);
    endtask

    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t pred;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                flow_addr[i] = '0;
                flow_bytes[i] = '0;
            end
            for (int c = 0; c < 4; c++)
                class_pkts[c] = '0;
            flow_count = 0;
            pkt_total = '0;
            byte_total = '0;
            expected_reports.delete();
            errs = 0;
            n_match = 0;
            n_insert = 0;
            n_full = 0;
            outstanding <= 0;
            mismatches <= 0;
            matched <= 0;
            inserted <= 0;
            untracked <= 0;
        end
        else
        begin
            // result first: a new header may be taken at the same edge
            if (done)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result transfer with no header outstanding");
                    errs++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("outcome", CNT_W'(want.outcome), CNT_W'(result.outcome));
                    check_field("slot", CNT_W'(want.slot), CNT_W'(result.slot));
                    check_field("source_byte_count", want.source_byte_count,
                                result.source_byte_count);
                    check_field("protocol_class", CNT_W'(want.protocol_class),
                                CNT_W'(result.protocol_class));
                    check_field("class_packet_count", want.class_packet_count,
                                result.class_packet_count);
                    check_field("packet_total", want.packet_total, result.packet_total);
                    check_field("byte_total", want.byte_total, result.byte_total);
                    check_field("sources_tracked", CNT_W'(want.sources_tracked),
                                CNT_W'(result.sources_tracked));
                    case (want.outcome)
                        OUTCOME_MATCH:  n_match++;
                        OUTCOME_INSERT: n_insert++;
                        default:        n_full++;
                    endcase
                end
            end
            if (start && !busy)
            begin
                account_packet(header, pred);
                expected_reports.push_back(pred);
            end
            outstanding <= expected_reports.size();
            mismatches <= errs;
            matched <= n_match;
            inserted <= n_insert;
            untracked <= n_full;
        end
    end

endmodule

`default_nettype wire

// ----- tb/source_byte_counter_table_tb.sv -----
`default_nettype none

module source_byte_counter_table_tb;

    import sbct_pkg::*;

    localparam int RANDOM_PACKETS = 600;
    localparam int CYCLE_LIMIT = 1000000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    header_t header = '0;
    logic    busy;
    logic    done;
    result_t result;

    int outstanding;
    int mismatches;
    int matched;
    int inserted;
    int untracked;
    int cycle_count = 0;

    // distinct addresses in the order first sent; the first entries are the tracked ones
    logic [ADDR_W-1:0] known_addrs[$];
    bit                addr_seen[logic [ADDR_W-1:0]];

    always #2 clk = ~clk;

    source_byte_counter_table u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .header (header),
        .done   (done),
        .result (result)
    );

    source_byte_counter_table_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .header      (header),
        .done        (done),
        .result      (result),
        .outstanding (outstanding),
        .mismatches  (mismatches),
        .matched     (matched),
        .inserted    (inserted),
        .untracked   (untracked)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // start is left high so a burst can continue straight into the next header
    task automatic send_packet(input logic [ADDR_W-1:0] addr, input logic [PROTO_W-1:0] proto,
                               input logic [LEN_W-1:0] len);
        header_t h;
        h.source_address = addr;
        h.protocol_number = proto;
        h.packet_length = len;
        if (!addr_seen.exists(addr))
        begin
            addr_seen[addr] = 1'b1;
            known_addrs.push_back(addr);
        end
        start <= 1'b1;
        header <= h;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                unsigned burst_left;
        int                unsigned gap;
        int                unsigned r;
        int                tracked_n;
        logic [ADDR_W-1:0] addr;
        logic [PROTO_W-1:0] proto;
        logic [LEN_W-1:0]  len;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // address zero, zero length, full length, each class and its neighbors
        send_packet(32'h0000_0000, PROTO_TCP, 16'h0000);
        send_packet(32'h0000_0000, PROTO_UDP, 16'hFFFF);
        send_packet(32'hFFFF_FFFF, PROTO_ICMP, 16'h0001);
        send_packet(32'hFFFF_FFFF, 8'd0, 16'hFFFF);
        send_packet(32'hAAAA_AAAA, 8'hFF, 16'h5555);
        send_packet(32'h5555_5555, 8'hAA, 16'hAAAA);
        send_packet(32'h0000_0000, PROTO_TCP, 16'h0000);
        send_packet(32'h5555_5555, 8'h55, 16'h0000);
        send_packet(32'h0000_0001, 8'd5, 16'd64);
        send_packet(32'h8000_0000, 8'd7, 16'd1500);
        send_packet(32'hAAAA_AAAA, 8'd16, 16'd40);
        send_packet(32'hFFFF_FFFF, 8'd18, 16'hFFFF);
        send_packet(32'h0000_0001, 8'd2, 16'd9000);
        send_packet(32'h8000_0000, PROTO_UDP, 16'd0);
        // idle the sender until every result is back
        wait_drained();

        burst_left = 0;
        for (int n = 0; n < RANDOM_PACKETS; n++)
        begin
            if (n == RANDOM_PACKETS / 2)
                wait_drained();
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200)
                                                  : $urandom_range(0, 12);
                if (gap != 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 8);
            end
            burst_left--;

            tracked_n = (known_addrs.size() < TABLE_ENTRIES_DEF) ? known_addrs.size()
                                                                 : TABLE_ENTRIES_DEF;
            r = $urandom_range(0, 99);
            if (r < 30 || tracked_n == 0)
                addr = $urandom;
            else if (r < 45 && known_addrs.size() > TABLE_ENTRIES_DEF)
                addr = known_addrs[$urandom_range(TABLE_ENTRIES_DEF, known_addrs.size() - 1)];
            else
                addr = known_addrs[$urandom_range(0, tracked_n - 1)];

            r = $urandom_range(0, 9);
            case (r)
                0, 1:    proto = PROTO_TCP;
                2, 3:    proto = PROTO_UDP;
                4:       proto = PROTO_ICMP;
                default: proto = PROTO_W'($urandom_range(0, 255));
            endcase

            r = $urandom_range(0, 9);
            if (r == 0)
                len = '0;
            else if (r == 1)
                len = '1;
            else
                len = LEN_W'($urandom);

            send_packet(addr, proto, len);
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("covered %0d headers: %0d matched, %0d inserted, %0d not tracked",
                 matched + inserted + untracked, matched, inserted, untracked);
        $display("%0d distinct sources offered against a table of %0d entries",
                 known_addrs.size(), TABLE_ENTRIES_DEF);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
